// File: rtl/core/ladder_keypad_command_decoder_macros.svh
// ----------------------------------------------------------------------------
// Ladder keypad command decoder assertion macros
// Small wrappers for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef LADDER_KEYPAD_COMMAND_DECODER_MACROS_SVH
`define LADDER_KEYPAD_COMMAND_DECODER_MACROS_SVH

// same-cycle implication
`define LKCD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkcd same-cycle check failed");

// next-cycle implication
`define LKCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkcd next-cycle check failed");

`endif

// File: rtl/core/lkcd_pkg.sv
// ----------------------------------------------------------------------------
// Ladder keypad command decoder package
// Shared codes, register indexes and the types passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkcd_pkg;

   localparam int SampleWidth = 10;
   localparam int TimeWidth   = 32;
   localparam int HoldWidth   = 16;
   localparam int LevelWidth  = 8;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 48;   // 42 bits of fields, zero padded
   localparam int RspDataWidth = 16;   // 14 bits of fields, zero padded

   typedef enum logic [2:0] {
      BTN_RIGHT  = 3'd0,
      BTN_UP     = 3'd1,
      BTN_DOWN   = 3'd2,
      BTN_LEFT   = 3'd3,
      BTN_SELECT = 3'd4,
      BTN_NONE   = 3'd5
   } button_type;

   typedef enum logic [1:0] {
      CMD_KEEP    = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_REWIND  = 2'd2
   } command_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_THR_RIGHT  = 3'd0,
      CSR_THR_UP     = 3'd1,
      CSR_THR_DOWN   = 3'd2,
      CSR_THR_LEFT   = 3'd3,
      CSR_THR_SELECT = 3'd4,
      CSR_LONG_PRESS = 3'd5,
      CSR_BRT_STEP   = 3'd6
   } csr_index_type;

   localparam logic [SampleWidth-1:0] ThrRightReset  = 10'd50;
   localparam logic [SampleWidth-1:0] ThrUpReset     = 10'd250;
   localparam logic [SampleWidth-1:0] ThrDownReset   = 10'd450;
   localparam logic [SampleWidth-1:0] ThrLeftReset   = 10'd650;
   localparam logic [SampleWidth-1:0] ThrSelectReset = 10'd850;
   localparam logic [HoldWidth-1:0]   LongPressReset = 16'd2000;
   localparam logic [LevelWidth-1:0]  BrtStepReset   = 8'd25;
   localparam logic [LevelWidth-1:0]  BrightReset    = 8'd127;
   localparam logic [LevelWidth-1:0]  BrightMax      = 8'd255;

   typedef struct packed {
      logic [SampleWidth-1:0] right;
      logic [SampleWidth-1:0] up;
      logic [SampleWidth-1:0] down;
      logic [SampleWidth-1:0] left;
      logic [SampleWidth-1:0] select;
   } thresholds_type;

   typedef struct packed {
      button_type             button;
      command_type            command;
      logic [LevelWidth-1:0]  level;
      logic                   changed;
   } result_type;

endpackage

// File: rtl/core/lkcd_classify.sv
// ----------------------------------------------------------------------------
// Ladder keypad sample classifier
// Priority compare of one sample against the five button thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkcd_classify (
   input  logic [lkcd_pkg::SampleWidth-1:0] sample,
   input  lkcd_pkg::thresholds_type         thresholds,
   output lkcd_pkg::button_type             button
);
   import lkcd_pkg::*;

   // first threshold that holds wins, even if unordered
   always_comb begin
      if (sample < thresholds.right) begin
         button = BTN_RIGHT;
      end else if (sample < thresholds.up) begin
         button = BTN_UP;
      end else if (sample < thresholds.down) begin
         button = BTN_DOWN;
      end else if (sample < thresholds.left) begin
         button = BTN_LEFT;
      end else if (sample < thresholds.select) begin
         button = BTN_SELECT;
      end else begin
         button = BTN_NONE;
      end
   end

endmodule

// File: rtl/core/lkcd_ctrl.sv
// ----------------------------------------------------------------------------
// Ladder keypad press controller
// Press tracking, long-press rewind and saturating brightness state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkcd_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  lkcd_pkg::button_type             button,
   input  logic [lkcd_pkg::TimeWidth-1:0]   time_ms,
   input  logic [lkcd_pkg::HoldWidth-1:0]   long_press_ms,
   input  logic [lkcd_pkg::LevelWidth-1:0]  brightness_step,
   output lkcd_pkg::result_type             result
);
   import lkcd_pkg::*;

   logic [LevelWidth-1:0] brightness_ff, brightness_in;
   logic [TimeWidth-1:0]  press_start_ff, press_start_in;
   logic                  held_ff, held_in;
   logic                  rewinding_ff, rewinding_in;

   logic [TimeWidth-1:0]  elapsed;
   logic                  long_done;
   logic [LevelWidth:0]   brt_sum;
   logic [LevelWidth-1:0] brt_up;
   logic [LevelWidth-1:0] brt_down;
   command_type           command;
   logic                  changed;

   assign elapsed   = time_ms - press_start_ff;   // wraps mod 2^32
   assign long_done = elapsed >= {{(TimeWidth-HoldWidth){1'b0}}, long_press_ms};
   assign brt_sum   = {1'b0, brightness_ff} + {1'b0, brightness_step};
   assign brt_up    = brt_sum[LevelWidth] ? BrightMax : brt_sum[LevelWidth-1:0];
   assign brt_down  = (brightness_ff > brightness_step) ?
                      brightness_ff - brightness_step : '0;

   always_comb begin
      brightness_in  = brightness_ff;
      press_start_in = press_start_ff;
      held_in        = held_ff;
      rewinding_in   = rewinding_ff;
      command        = CMD_KEEP;
      changed        = 1'b0;
      if (rewinding_ff && (button == BTN_NONE || button == BTN_SELECT)) begin
         command = CMD_REWIND;
      end else if (button == BTN_NONE) begin
         held_in = 1'b0;
      end else if (button == BTN_SELECT && !held_ff) begin
         held_in        = 1'b1;
         press_start_in = time_ms;
      end else if (button == BTN_SELECT && long_done) begin
         rewinding_in = 1'b1;
         command      = CMD_REWIND;
      end else if (rewinding_ff) begin
         rewinding_in = 1'b0;   // other press cancels rewind
      end else if (!held_ff) begin
         held_in        = 1'b1;
         press_start_in = time_ms;
         case (button)
            BTN_LEFT: begin
               brightness_in = brt_down;
               changed       = 1'b1;
            end
            BTN_RIGHT: begin
               brightness_in = brt_up;
               changed       = 1'b1;
            end
            BTN_DOWN: begin
               command = CMD_ADVANCE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BrightReset;
         press_start_ff <= '0;
         held_ff        <= 1'b0;
         rewinding_ff   <= 1'b0;
      end else if (step_en) begin
         brightness_ff  <= brightness_in;
         press_start_ff <= press_start_in;
         held_ff        <= held_in;
         rewinding_ff   <= rewinding_in;
      end
   end

   assign result.button  = button;
   assign result.command = command;
   assign result.level   = brightness_in;
   assign result.changed = changed;

endmodule

// File: rtl/core/ladder_keypad_command_decoder.sv
// ----------------------------------------------------------------------------
// Ladder keypad command decoder
// Turns resistor-ladder keypad samples into button, mode and brightness items.
// ----------------------------------------------------------------------------
// Each req item carries one 10-bit ladder sample and a free-running
// millisecond time; each one yields exactly one rsp item with the decoded
// button, a mode command (keep, advance, rewind), the brightness level and a
// changed flag. The item sits in the input register while the classify/press
// logic works on it, then the result register takes it and rsp_tvalid rises.
// One item is taken per cycle; req_tready drops only while both registers are
// full and rsp_tready is low. The press state updates as the item leaves the
// input register, so consecutive items see each other's state. Thresholds,
// long-press time and brightness step are written through the csr port and
// must only change
// while no item is in flight.
`timescale 1ns / 1ps

`include "ladder_keypad_command_decoder_macros.svh"

module ladder_keypad_command_decoder (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [9:0] adc_sample, [41:10] time_ms, [47:42] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lkcd_pkg::ReqDataWidth-1:0]   req_tdata,
   // rsp_tdata: [2:0] button_code, [4:3] mode_command,
   //            [12:5] brightness_level, [13] brightness_changed, [15:14] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lkcd_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                                csr_wen,
   input  logic [lkcd_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [lkcd_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import lkcd_pkg::*;

   // configuration registers
   thresholds_type        thr_ff;
   logic [HoldWidth-1:0]  long_press_ff;
   logic [LevelWidth-1:0] brt_step_ff;

   // input register
   logic                   s1_valid_ff;
   logic [SampleWidth-1:0] s1_sample_ff;
   logic [TimeWidth-1:0]   s1_time_ff;

   // result register
   logic                   rsp_valid_ff;
   result_type             rsp_ff;

   logic       advance;   // input register moves into the result register
   button_type button;
   result_type result;

   // assertion terms
   logic is_advance;
   logic is_changed;
   logic is_rewind;
   logic is_lr;
   logic is_sel_none;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.right  <= ThrRightReset;
         thr_ff.up     <= ThrUpReset;
         thr_ff.down   <= ThrDownReset;
         thr_ff.left   <= ThrLeftReset;
         thr_ff.select <= ThrSelectReset;
         long_press_ff <= LongPressReset;
         brt_step_ff   <= BrtStepReset;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_THR_RIGHT:  thr_ff.right  <= csr_wdata[SampleWidth-1:0];
            CSR_THR_UP:     thr_ff.up     <= csr_wdata[SampleWidth-1:0];
            CSR_THR_DOWN:   thr_ff.down   <= csr_wdata[SampleWidth-1:0];
            CSR_THR_LEFT:   thr_ff.left   <= csr_wdata[SampleWidth-1:0];
            CSR_THR_SELECT: thr_ff.select <= csr_wdata[SampleWidth-1:0];
            CSR_LONG_PRESS: long_press_ff <= csr_wdata[HoldWidth-1:0];
            CSR_BRT_STEP:   brt_step_ff   <= csr_wdata[LevelWidth-1:0];
            default: begin
               // unused index: ignored
            end
         endcase
      end
   end

   // input register: accepts whenever it is empty or draining this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_sample_ff <= req_tdata[SampleWidth-1:0];
         s1_time_ff   <= req_tdata[SampleWidth+TimeWidth-1:SampleWidth];
      end
   end

   lkcd_classify u_classify (
      .sample     (s1_sample_ff),
      .thresholds (thr_ff),
      .button     (button)
   );

   // press state commits only when the item actually moves on
   lkcd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .button          (button),
      .time_ms         (s1_time_ff),
      .long_press_ms   (long_press_ff),
      .brightness_step (brt_step_ff),
      .result          (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.changed, rsp_ff.level, rsp_ff.command, rsp_ff.button};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   assign is_advance  = rsp_valid_ff && rsp_ff.command == CMD_ADVANCE;
   assign is_changed  = rsp_valid_ff && rsp_ff.changed;
   assign is_rewind   = rsp_valid_ff && rsp_ff.command == CMD_REWIND;
   assign is_lr       = rsp_ff.button == BTN_LEFT || rsp_ff.button == BTN_RIGHT;
   assign is_sel_none = rsp_ff.button == BTN_SELECT || rsp_ff.button == BTN_NONE;

   `LKCD_ASSERT_IMPL(a_advance_is_down, clock, reset, is_advance, rsp_ff.button == BTN_DOWN)
   `LKCD_ASSERT_IMPL(a_changed_is_lr, clock, reset, is_changed, is_lr)
   `LKCD_ASSERT_IMPL(a_rewind_button, clock, reset, is_rewind, is_sel_none)
   `LKCD_ASSERT_NEXT(a_advance_lands, clock, reset, advance, rsp_valid_ff)

endmodule
